@@ rtl/evad_pkg.sv @@
package evad_pkg;

    // field widths
    localparam int LEN_W      = 16;
    localparam int TS_W       = 32;
    localparam int CHG_W      = 16;
    localparam int INTERVAL_W = 12;
    localparam int WEIGHT_W   = 17;
    localparam int THRESH_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH   = 2'd2;

    // register reset values
    localparam logic [INTERVAL_W-1:0] RST_INTERVAL = 12'd30;
    localparam logic [WEIGHT_W-1:0]   RST_WEIGHT   = 17'd58982;
    localparam logic [THRESH_W-1:0]   RST_THRESH   = 16'd768;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
    localparam logic [CHG_W-1:0]    CHG_SAT    = 16'hFFFF;

    localparam int Q_FRAC      = 8;   // ratio fraction bits
    localparam int EW_SHIFT    = 16;  // weight fraction bits
    localparam int RATIO_STEPS = 16;  // quotient bits of the ratio
    localparam int MUL_W       = 32;  // multiplier operand chunk

    localparam logic KIND_PKT   = 1'b0;
    localparam logic KIND_END   = 1'b1;
    localparam logic ATYPE_BYTE = 1'b0;
    localparam logic ATYPE_PKT  = 1'b1;

    typedef enum logic [1:0] {
        MOP_EST_TH,
        MOP_EST_WC,
        MOP_RATE_W
    } t_mul_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDIV_LD,
        ST_RDIV,
        ST_RATE_WR,
        ST_SEED,
        ST_TH_MUL,
        ST_TH_ADD,
        ST_CMP,
        ST_QDIV,
        ST_Q_WR,
        ST_EW_MUL,
        ST_EW_ADD,
        ST_EW_WR,
        ST_DECIDE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic    acc_pkt;
        logic    div_load;
        logic    div_step;
        logic    rate_wr;
        logic    seed;
        logic    mul;
        t_mul_op mul_op;
        logic    mul_chunk;
        logic    acc_add;
        logic    cmp;
        logic    quo_wr;
        logic    est_wr;
        logic    decide;
        logic    emit;
        logic    sel;       // 0 bytes, 1 packets
    } t_dp_cmd;

    typedef struct packed {
        logic       open;
        logic       hit;
        logic       sat;
        logic       out_free;
        logic [1:0] emit_mask;
    } t_dp_sts;

endpackage

@@ rtl/evad_if.sv @@
interface evad_item_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [evad_pkg::LEN_W-1:0]  pkt_len;
    logic [evad_pkg::TS_W-1:0]   ts_seconds;

    modport source (output valid, kind, pkt_len, ts_seconds, input ready);
    modport sink   (input valid, kind, pkt_len, ts_seconds, output ready);
endinterface

interface evad_alert_if;
    logic                        valid;
    logic                        ready;
    logic                        alert_type;
    logic [evad_pkg::CHG_W-1:0]  change_q8;
    logic [evad_pkg::TS_W-1:0]   alert_ts;
    logic                        last;

    modport source (output valid, alert_type, change_q8, alert_ts, last, input ready);
    modport sink   (input valid, alert_type, change_q8, alert_ts, last, output ready);
endinterface

interface evad_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [evad_pkg::CFG_IDX_W-1:0]   index;
    logic [evad_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/evad_ctrl.sv @@
module evad_ctrl #(
    parameter int DIV_STEPS  = 48,
    parameter int NUM_CHUNKS = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_kind,
    output logic              o_in_ready,
    input  evad_pkg::t_dp_sts i_sts,
    output evad_pkg::t_dp_cmd o_cmd
);

    localparam int SW = $clog2(DIV_STEPS);
    localparam logic [SW-1:0] DIV_LAST   = SW'(DIV_STEPS - 1);
    localparam logic [SW-1:0] RATIO_LAST = SW'(evad_pkg::RATIO_STEPS - 1);
    localparam logic          CHUNK_LAST = 1'(NUM_CHUNKS - 1);

    evad_pkg::t_state r_state, n_state;
    logic             r_sel, n_sel;
    logic [SW-1:0]    r_step, n_step;
    logic             r_chunk, n_chunk;
    logic             r_term, n_term;   // 0 old estimate term, 1 new rate term

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= evad_pkg::ST_IDLE;
            r_sel   <= 1'b0;
            r_step  <= '0;
            r_chunk <= 1'b0;
            r_term  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_step  <= n_step;
            r_chunk <= n_chunk;
            r_term  <= n_term;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_step  = r_step;
        n_chunk = r_chunk;
        n_term  = r_term;
        unique case (r_state)
            evad_pkg::ST_IDLE: begin
                if (i_in_valid && i_in_kind == evad_pkg::KIND_END && i_sts.open) begin
                    n_state = evad_pkg::ST_RDIV_LD;
                    n_sel   = 1'b0;
                end
            end
            evad_pkg::ST_RDIV_LD: begin
                n_state = evad_pkg::ST_RDIV;
                n_step  = '0;
            end
            evad_pkg::ST_RDIV: begin
                n_step = r_step + 1'b1;
                if (r_step == DIV_LAST) begin
                    n_state = evad_pkg::ST_RATE_WR;
                end
            end
            evad_pkg::ST_RATE_WR: begin
                if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_state = evad_pkg::ST_RDIV_LD;
                end else begin
                    n_sel   = 1'b0;
                    n_state = evad_pkg::ST_SEED;
                end
            end
            evad_pkg::ST_SEED: begin
                n_state = evad_pkg::ST_TH_MUL;
                n_chunk = 1'b0;
            end
            evad_pkg::ST_TH_MUL: begin
                n_state = evad_pkg::ST_TH_ADD;
            end
            evad_pkg::ST_TH_ADD: begin
                if (r_chunk == CHUNK_LAST) begin
                    n_state = evad_pkg::ST_CMP;
                end else begin
                    n_chunk = r_chunk + 1'b1;
                    n_state = evad_pkg::ST_TH_MUL;
                end
            end
            evad_pkg::ST_CMP: begin
                if (i_sts.hit && !i_sts.sat) begin
                    n_state = evad_pkg::ST_QDIV;
                    n_step  = '0;
                end else begin
                    n_state = evad_pkg::ST_EW_MUL;
                    n_chunk = 1'b0;
                    n_term  = 1'b0;
                end
            end
            evad_pkg::ST_QDIV: begin
                n_step = r_step + 1'b1;
                if (r_step == RATIO_LAST) begin
                    n_state = evad_pkg::ST_Q_WR;
                end
            end
            evad_pkg::ST_Q_WR: begin
                n_state = evad_pkg::ST_EW_MUL;
                n_chunk = 1'b0;
                n_term  = 1'b0;
            end
            evad_pkg::ST_EW_MUL: begin
                n_state = evad_pkg::ST_EW_ADD;
            end
            evad_pkg::ST_EW_ADD: begin
                if (r_chunk != CHUNK_LAST) begin
                    n_chunk = r_chunk + 1'b1;
                    n_state = evad_pkg::ST_EW_MUL;
                end else if (!r_term) begin
                    n_term  = 1'b1;
                    n_chunk = 1'b0;
                    n_state = evad_pkg::ST_EW_MUL;
                end else begin
                    n_state = evad_pkg::ST_EW_WR;
                end
            end
            evad_pkg::ST_EW_WR: begin
                if (!r_sel) begin
                    n_sel   = 1'b1;
                    n_chunk = 1'b0;
                    n_state = evad_pkg::ST_TH_MUL;
                end else begin
                    n_state = evad_pkg::ST_DECIDE;
                end
            end
            evad_pkg::ST_DECIDE: begin
                n_state = evad_pkg::ST_EMIT;
            end
            evad_pkg::ST_EMIT: begin
                if (i_sts.emit_mask == 2'b00) begin
                    n_state = evad_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = evad_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd           = '0;
        o_cmd.sel       = r_sel;
        o_cmd.mul_chunk = r_chunk;
        o_cmd.mul_op    = evad_pkg::MOP_EST_TH;
        o_in_ready      = 1'b0;
        unique case (r_state)
            evad_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.acc_pkt = i_in_valid && i_in_kind == evad_pkg::KIND_PKT;
            end
            evad_pkg::ST_RDIV_LD: o_cmd.div_load = 1'b1;
            evad_pkg::ST_RDIV:    o_cmd.div_step = 1'b1;
            evad_pkg::ST_RATE_WR: o_cmd.rate_wr  = 1'b1;
            evad_pkg::ST_SEED:    o_cmd.seed     = 1'b1;
            evad_pkg::ST_TH_MUL:  o_cmd.mul      = 1'b1;
            evad_pkg::ST_TH_ADD:  o_cmd.acc_add  = 1'b1;
            evad_pkg::ST_CMP:     o_cmd.cmp      = 1'b1;
            evad_pkg::ST_QDIV:    o_cmd.div_step = 1'b1;
            evad_pkg::ST_Q_WR:    o_cmd.quo_wr   = 1'b1;
            evad_pkg::ST_EW_MUL: begin
                o_cmd.mul    = 1'b1;
                o_cmd.mul_op = r_term ? evad_pkg::MOP_RATE_W : evad_pkg::MOP_EST_WC;
            end
            evad_pkg::ST_EW_ADD:  o_cmd.acc_add  = 1'b1;
            evad_pkg::ST_EW_WR:   o_cmd.est_wr   = 1'b1;
            evad_pkg::ST_DECIDE:  o_cmd.decide   = 1'b1;
            evad_pkg::ST_EMIT: begin
                o_cmd.emit = (i_sts.emit_mask != 2'b00) && i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    as_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == evad_pkg::ST_QDIV) |-> (r_step <= RATIO_LAST))
        else $error("ratio division ran past its quotient bits");

    as_emit_only_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == evad_pkg::ST_EMIT && i_sts.emit_mask != 2'b00))
        else $error("record emitted with nothing pending");

    as_end_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == evad_pkg::ST_IDLE && i_in_valid && i_in_kind == evad_pkg::KIND_END
         && i_sts.open) |=> (r_state == evad_pkg::ST_RDIV_LD && !r_sel))
        else $error("interval end with open interval not processed");

endmodule

@@ rtl/evad_dp.sv @@
module evad_dp #(
    parameter int BW = 48,
    parameter int PW = 40
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  evad_pkg::t_dp_cmd                 i_cmd,
    output evad_pkg::t_dp_sts                 o_sts,
    input  logic [evad_pkg::LEN_W-1:0]        i_pkt_len,
    input  logic [evad_pkg::TS_W-1:0]         i_ts_seconds,
    input  logic                              i_cfg_wr,
    input  logic [evad_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [evad_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_alert_type,
    output logic [evad_pkg::CHG_W-1:0]        o_change_q8,
    output logic [evad_pkg::TS_W-1:0]         o_alert_ts,
    output logic                              o_last
);

    localparam int MW  = (BW > PW) ? BW : PW;
    localparam int NCH = (MW + evad_pkg::MUL_W - 1) / evad_pkg::MUL_W;
    localparam int OPW = NCH * evad_pkg::MUL_W;
    localparam int AW  = OPW + 18;
    localparam int PRW = evad_pkg::MUL_W + evad_pkg::WEIGHT_W;

    // configuration
    logic [evad_pkg::INTERVAL_W-1:0] r_interval;
    logic [evad_pkg::WEIGHT_W-1:0]   r_weight;
    logic [evad_pkg::THRESH_W-1:0]   r_thresh;

    // interval and estimates
    logic [BW-1:0]              r_byte_sum, r_rate_b, r_est_b;
    logic [PW-1:0]              r_pkt_sum, r_rate_p, r_est_p;
    logic [evad_pkg::TS_W-1:0]  r_first_ts;
    logic                       r_open, r_est_valid;
    logic [1:0]                 r_prev, r_cur, r_emit;
    logic [evad_pkg::CHG_W-1:0] r_chg_b, r_chg_p;

    // divider, multiplier
    logic [MW-1:0]  r_rem, r_quo, r_dvsr;
    logic [PRW-1:0] r_prod;
    logic           r_pchunk;
    logic [AW-1:0]  r_acc;

    // output word
    logic                       r_out_valid, r_alert_type, r_last;
    logic [evad_pkg::CHG_W-1:0] r_change_q8;
    logic [evad_pkg::TS_W-1:0]  r_alert_ts;

    logic [evad_pkg::INTERVAL_W-1:0] div_v;
    logic [evad_pkg::WEIGHT_W-1:0]   w_eff, w_cmp, mul_b;
    logic [MW-1:0]                   rate_sel, est_sel, mul_src;
    logic [OPW-1:0]                  opnd;
    logic [evad_pkg::MUL_W-1:0]      mul_a;
    logic [BW:0]                     byte_add;
    logic [MW:0]                     div_t;
    logic                            div_ge;
    logic                            hit, sat;
    logic [1:0]                      sel_bit, prev_and;
    logic                            out_free;

    assign div_v = (r_interval == '0) ? evad_pkg::INTERVAL_W'(1) : r_interval;
    assign w_eff = (r_weight > evad_pkg::WEIGHT_ONE) ? evad_pkg::WEIGHT_ONE : r_weight;
    assign w_cmp = evad_pkg::WEIGHT_ONE - w_eff;

    assign rate_sel = i_cmd.sel ? MW'(r_rate_p) : MW'(r_rate_b);
    assign est_sel  = i_cmd.sel ? MW'(r_est_p)  : MW'(r_est_b);
    assign sel_bit  = i_cmd.sel ? 2'b10 : 2'b01;

    assign byte_add = {1'b0, r_byte_sum} + (BW + 1)'(i_pkt_len);

    // one restoring step; remainder stays below the divisor
    assign div_t  = {r_rem, r_quo[MW-1]};
    assign div_ge = div_t >= {1'b0, r_dvsr};

    // rate*256 > threshold*estimate; ratio saturates once rate >= 256*estimate
    assign hit = AW'({rate_sel, {evad_pkg::Q_FRAC{1'b0}}}) > r_acc;
    assign sat = {{evad_pkg::Q_FRAC{1'b0}}, rate_sel} >= {est_sel, {evad_pkg::Q_FRAC{1'b0}}};

    assign mul_src = (i_cmd.mul_op == evad_pkg::MOP_RATE_W) ? rate_sel : est_sel;
    assign opnd    = OPW'(mul_src);
    assign mul_a   = (i_cmd.mul_chunk && NCH > 1) ? opnd[OPW-1 -: evad_pkg::MUL_W]
                                                  : opnd[evad_pkg::MUL_W-1:0];
    always_comb begin
        unique case (i_cmd.mul_op)
            evad_pkg::MOP_EST_TH: mul_b = evad_pkg::WEIGHT_W'(r_thresh);
            evad_pkg::MOP_EST_WC: mul_b = w_cmp;
            evad_pkg::MOP_RATE_W: mul_b = w_eff;
            default:              mul_b = '0;
        endcase
    end

    assign prev_and = r_prev & r_cur;
    assign out_free = !r_out_valid || i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval  <= evad_pkg::RST_INTERVAL;
            r_weight    <= evad_pkg::RST_WEIGHT;
            r_thresh    <= evad_pkg::RST_THRESH;
            r_open      <= 1'b0;
            r_est_valid <= 1'b0;
            r_prev      <= 2'b00;
            r_emit      <= 2'b00;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr) begin
                unique case (i_cfg_index)
                    evad_pkg::CFG_INTERVAL: r_interval <= i_cfg_data[evad_pkg::INTERVAL_W-1:0];
                    evad_pkg::CFG_WEIGHT:   r_weight   <= i_cfg_data[evad_pkg::WEIGHT_W-1:0];
                    evad_pkg::CFG_THRESH:   r_thresh   <= i_cfg_data[evad_pkg::THRESH_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.acc_pkt) begin
                r_open <= 1'b1;
            end
            if (i_cmd.seed) begin
                r_est_valid <= 1'b1;
            end
            if (i_cmd.decide) begin
                r_open <= 1'b0;
                if (prev_and != 2'b00) begin
                    r_prev <= prev_and;
                    r_emit <= 2'b00;
                end else begin
                    r_prev <= r_cur;
                    r_emit <= r_cur;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                if (r_emit[0]) begin
                    r_emit[0] <= 1'b0;
                end else begin
                    r_emit[1] <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_pkt) begin
            if (!r_open) begin
                r_byte_sum <= BW'(i_pkt_len);
                r_pkt_sum  <= PW'(1);
                r_first_ts <= i_ts_seconds;
            end else begin
                r_byte_sum <= byte_add[BW] ? '1 : byte_add[BW-1:0];
                if (r_pkt_sum != '1) begin
                    r_pkt_sum <= r_pkt_sum + 1'b1;
                end
            end
        end

        if (i_cmd.div_load) begin
            r_rem  <= '0;
            r_quo  <= i_cmd.sel ? MW'(r_pkt_sum) : MW'(r_byte_sum);
            r_dvsr <= MW'(div_v);
        end else if (i_cmd.cmp && hit && !sat) begin
            r_rem  <= MW'(rate_sel >> evad_pkg::Q_FRAC);
            r_quo  <= {rate_sel[evad_pkg::Q_FRAC-1:0], {(MW - evad_pkg::Q_FRAC){1'b0}}};
            r_dvsr <= est_sel;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? MW'(div_t - {1'b0, r_dvsr}) : div_t[MW-1:0];
            r_quo <= {r_quo[MW-2:0], div_ge};
        end

        if (i_cmd.rate_wr) begin
            if (i_cmd.sel) begin
                r_rate_p <= r_quo[PW-1:0];
            end else begin
                r_rate_b <= r_quo[BW-1:0];
            end
        end

        if (i_cmd.seed) begin
            r_cur <= 2'b00;
            if (!r_est_valid) begin
                r_est_b <= r_rate_b;
                r_est_p <= r_rate_p;
            end
        end

        if (i_cmd.mul) begin
            r_prod   <= {{evad_pkg::WEIGHT_W{1'b0}}, mul_a} * {{evad_pkg::MUL_W{1'b0}}, mul_b};
            r_pchunk <= i_cmd.mul_chunk;
            if (!i_cmd.mul_chunk && i_cmd.mul_op != evad_pkg::MOP_RATE_W) begin
                r_acc <= '0;
            end
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + (r_pchunk ? (AW'(r_prod) << evad_pkg::MUL_W) : AW'(r_prod));
        end

        if (i_cmd.cmp && hit) begin
            r_cur <= r_cur | sel_bit;
            if (sat) begin
                if (i_cmd.sel) begin
                    r_chg_p <= evad_pkg::CHG_SAT;
                end else begin
                    r_chg_b <= evad_pkg::CHG_SAT;
                end
            end
        end

        if (i_cmd.quo_wr) begin
            if (i_cmd.sel) begin
                r_chg_p <= r_quo[evad_pkg::CHG_W-1:0];
            end else begin
                r_chg_b <= r_quo[evad_pkg::CHG_W-1:0];
            end
        end

        if (i_cmd.est_wr) begin
            if (i_cmd.sel) begin
                r_est_p <= r_acc[evad_pkg::EW_SHIFT +: PW];
            end else begin
                r_est_b <= r_acc[evad_pkg::EW_SHIFT +: BW];
            end
        end

        if (i_cmd.emit) begin
            r_alert_ts <= r_first_ts;
            if (r_emit[0]) begin
                r_alert_type <= evad_pkg::ATYPE_BYTE;
                r_change_q8  <= r_chg_b;
                r_last       <= !r_emit[1];
            end else begin
                r_alert_type <= evad_pkg::ATYPE_PKT;
                r_change_q8  <= r_chg_p;
                r_last       <= 1'b1;
            end
        end
    end

    assign o_sts.open      = r_open;
    assign o_sts.hit       = hit;
    assign o_sts.sat       = sat;
    assign o_sts.out_free  = out_free;
    assign o_sts.emit_mask = r_emit;

    assign o_out_valid  = r_out_valid;
    assign o_alert_type = r_alert_type;
    assign o_change_q8  = r_change_q8;
    assign o_alert_ts   = r_alert_ts;
    assign o_last       = r_last;

    as_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> out_free)
        else $error("output word overwritten before it was taken");

    as_cmp_seeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cmp |-> r_est_valid)
        else $error("compare against an unseeded estimate");

    as_emit_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.decide |=> ((r_emit & ~r_cur) == 2'b00 && !r_open))
        else $error("emit mask holds an alert not raised this interval");

endmodule

@@ rtl/ewma_volume_anomaly_detector.sv @@
// Packet word: accepted while idle, one per cycle; it updates the sums and opens
// the interval. Interval end with an open interval: two MW-step rate divisions
// on the shared restoring divider (MW = wider sum width), estimate seeding,
// threshold products in NCH 32-bit multiplier chunks, a ratio division per
// unsaturated alert, EWMA updates, then one alert record per alert not muted.
// Reset (synchronous, active low): registers to defaults, estimates unseeded.
module ewma_volume_anomaly_detector #(
    parameter int BYTE_SUM_WIDTH   = 48,
    parameter int PACKET_SUM_WIDTH = 40
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    evad_item_if.sink    i_item,
    evad_alert_if.source o_alert,
    evad_cfg_if.sink     i_cfg
);

    localparam int MW  = (BYTE_SUM_WIDTH > PACKET_SUM_WIDTH) ? BYTE_SUM_WIDTH
                                                             : PACKET_SUM_WIDTH;
    localparam int NCH = (MW + evad_pkg::MUL_W - 1) / evad_pkg::MUL_W;

    evad_pkg::t_dp_cmd cmd;
    evad_pkg::t_dp_sts sts;

    assign i_cfg.ready = 1'b1;

    evad_ctrl #(
        .DIV_STEPS  (MW),
        .NUM_CHUNKS (NCH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_kind  (i_item.kind),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    evad_dp #(
        .BW (BYTE_SUM_WIDTH),
        .PW (PACKET_SUM_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_pkt_len    (i_item.pkt_len),
        .i_ts_seconds (i_item.ts_seconds),
        .i_cfg_wr     (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_out_valid  (o_alert.valid),
        .i_out_ready  (o_alert.ready),
        .o_alert_type (o_alert.alert_type),
        .o_change_q8  (o_alert.change_q8),
        .o_alert_ts   (o_alert.alert_ts),
        .o_last       (o_alert.last)
    );

endmodule

@@ tb/sv/tb.sv @@
class alert_scoreboard;
    typedef struct {
        bit                       alert_type;
        bit [evad_pkg::CHG_W-1:0] change_q8;
        bit [evad_pkg::TS_W-1:0]  alert_ts;
        bit                       last;
    } t_alert_word;

    localparam bit [63:0] BYTE_MAX = 64'h0000_FFFF_FFFF_FFFF;
    localparam bit [63:0] PKT_MAX  = 64'h0000_00FF_FFFF_FFFF;

    bit [evad_pkg::INTERVAL_W-1:0] interval_s;
    bit [evad_pkg::WEIGHT_W-1:0]   weight;
    bit [evad_pkg::THRESH_W-1:0]   thresh;

    bit [63:0]                byte_sum;
    bit [63:0]                pkt_sum;
    bit [evad_pkg::TS_W-1:0]  first_ts;
    bit                       open;
    bit [63:0]                est_bytes;
    bit [63:0]                est_pkts;
    bit                       est_valid;
    bit [1:0]                 prev_alerts;

    t_alert_word expected_alerts[$];
    int errors;
    int alerts_checked;
    int intervals_closed;
    int reg_writes;

    function new();
        interval_s  = evad_pkg::RST_INTERVAL;
        weight      = evad_pkg::RST_WEIGHT;
        thresh      = evad_pkg::RST_THRESH;
        byte_sum    = '0;
        pkt_sum     = '0;
        first_ts    = '0;
        open        = 1'b0;
        est_bytes   = '0;
        est_pkts    = '0;
        est_valid   = 1'b0;
        prev_alerts = '0;
    endfunction

    task report(string msg);
        errors++;
        $display("%0t ERROR %s", $time, msg);
    endtask

    function void note_config(bit [evad_pkg::CFG_IDX_W-1:0] idx,
                              bit [evad_pkg::CFG_DATA_W-1:0] data);
        reg_writes++;
        case (idx)
            evad_pkg::CFG_INTERVAL: interval_s = data[evad_pkg::INTERVAL_W-1:0];
            evad_pkg::CFG_WEIGHT:   weight     = data[evad_pkg::WEIGHT_W-1:0];
            evad_pkg::CFG_THRESH:   thresh     = data[evad_pkg::THRESH_W-1:0];
            default: ;
        endcase
    endfunction

    // rate*256 > th*est, exact
    static function bit over_threshold(bit [63:0] rate, bit [63:0] est,
                                       bit [evad_pkg::THRESH_W-1:0] th);
        bit [95:0] lhs;
        bit [95:0] rhs;
        lhs = {24'd0, rate, 8'd0};
        rhs = {32'd0, est} * {80'd0, th};
        return lhs > rhs;
    endfunction

    // floor(rate*256/est), saturating; zero estimate saturates
    static function bit [evad_pkg::CHG_W-1:0] ratio_q8(bit [63:0] rate, bit [63:0] est);
        bit [79:0] q;
        if (est == 0)
            return evad_pkg::CHG_SAT;
        q = {8'd0, rate, 8'd0} / {16'd0, est};
        return (q > {64'd0, evad_pkg::CHG_SAT}) ? evad_pkg::CHG_SAT : q[evad_pkg::CHG_W-1:0];
    endfunction

    static function bit [63:0] blend(bit [63:0] est, bit [63:0] rate,
                                     bit [evad_pkg::WEIGHT_W-1:0] w);
        bit [95:0] acc;
        acc = {32'd0, est} * {79'd0, evad_pkg::WEIGHT_ONE - w} + {32'd0, rate} * {79'd0, w};
        return acc[79:16];
    endfunction

    // returns 0 when the word is ignored (interval end with nothing open)
    function bit note_item(bit kind, bit [evad_pkg::LEN_W-1:0] len,
                           bit [evad_pkg::TS_W-1:0] ts);
        bit [63:0]                   div;
        bit [63:0]                   rate_b;
        bit [63:0]                   rate_p;
        bit [evad_pkg::WEIGHT_W-1:0] w;
        bit [1:0]                    hits;
        bit [1:0]                    repeated;
        bit [evad_pkg::CHG_W-1:0]    chg_b;
        bit [evad_pkg::CHG_W-1:0]    chg_p;
        t_alert_word                 rec;

        if (kind == evad_pkg::KIND_PKT) begin
            if (!open) begin
                open     = 1'b1;
                byte_sum = '0;
                pkt_sum  = '0;
                first_ts = ts;
            end
            if (BYTE_MAX - byte_sum < {48'd0, len})
                byte_sum = BYTE_MAX;
            else
                byte_sum = byte_sum + {48'd0, len};
            if (pkt_sum != PKT_MAX)
                pkt_sum = pkt_sum + 64'd1;
            return 1'b1;
        end
        if (!open)
            return 1'b0;

        div    = (interval_s == 0) ? 64'd1 : {52'd0, interval_s};
        w      = (weight > evad_pkg::WEIGHT_ONE) ? evad_pkg::WEIGHT_ONE : weight;
        rate_b = byte_sum / div;
        rate_p = pkt_sum / div;

        if (!est_valid) begin
            est_bytes = rate_b;
            est_pkts  = rate_p;
            est_valid = 1'b1;
        end

        hits  = '0;
        chg_b = '0;
        chg_p = '0;
        if (over_threshold(rate_b, est_bytes, thresh)) begin
            hits[0] = 1'b1;
            chg_b   = ratio_q8(rate_b, est_bytes);
        end
        if (over_threshold(rate_p, est_pkts, thresh)) begin
            hits[1] = 1'b1;
            chg_p   = ratio_q8(rate_p, est_pkts);
        end

        est_bytes = blend(est_bytes, rate_b, w) & BYTE_MAX;
        est_pkts  = blend(est_pkts, rate_p, w) & PKT_MAX;

        // any alert repeated from the last interval mutes the whole interval
        repeated = prev_alerts & hits;
        if (repeated != 0) begin
            prev_alerts = repeated;
            hits        = '0;
        end else begin
            prev_alerts = hits;
        end

        if (hits[0]) begin
            rec = '{evad_pkg::ATYPE_BYTE, chg_b, first_ts, ~hits[1]};
            expected_alerts.push_back(rec);
        end
        if (hits[1]) begin
            rec = '{evad_pkg::ATYPE_PKT, chg_p, first_ts, 1'b1};
            expected_alerts.push_back(rec);
        end

        open     = 1'b0;
        byte_sum = '0;
        pkt_sum  = '0;
        intervals_closed++;
        return 1'b1;
    endfunction

    task check_alert(logic atype, logic [evad_pkg::CHG_W-1:0] chg,
                     logic [evad_pkg::TS_W-1:0] ts, logic last);
        t_alert_word want;
        if (expected_alerts.size() == 0) begin
            report($sformatf("unexpected alert word type %0d change %0d ts %0d last %0d",
                             atype, chg, ts, last));
            return;
        end
        want = expected_alerts.pop_front();
        alerts_checked++;
        if (atype !== want.alert_type)
            report($sformatf("alert_type %0d, want %0d", atype, want.alert_type));
        if (chg !== want.change_q8)
            report($sformatf("change_q8 %0d, want %0d (type %0d)", chg, want.change_q8,
                             want.alert_type));
        if (ts !== want.alert_ts)
            report($sformatf("alert_ts %0d, want %0d", ts, want.alert_ts));
        if (last !== want.last)
            report($sformatf("last %0d, want %0d", last, want.last));
    endtask
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int END_LATENCY   = 200;
    localparam int STALL_LIMIT   = 5000;
    localparam int TARGET_ITEMS  = 550;
    localparam int PHASE_ITEMS   = 64;
    localparam logic [evad_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    evad_item_if  item_bus ();
    evad_alert_if alert_bus ();
    evad_cfg_if   cfg_bus ();

    ewma_volume_anomaly_detector i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_bus),
        .o_alert (alert_bus),
        .i_cfg   (cfg_bus)
    );

    alert_scoreboard sb = new();

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int items_sent     = 0;
    int quiet_cycles   = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        alert_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            alert_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && alert_bus.valid && alert_bus.ready)
            sb.check_alert(alert_bus.alert_type, alert_bus.change_q8, alert_bus.alert_ts,
                           alert_bus.last);
        if ((item_bus.valid && item_bus.ready) || (alert_bus.valid && alert_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic kind, input logic [evad_pkg::LEN_W-1:0] len,
                             input logic [evad_pkg::TS_W-1:0] ts);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            item_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        item_bus.valid      = 1'b1;
        item_bus.kind       = kind;
        item_bus.pkt_len    = len;
        item_bus.ts_seconds = ts;
        do @(posedge i_clk); while (!item_bus.ready);
        if (sb.note_item(kind, len, ts))
            items_sent++;
    endtask

    task automatic send_end();
        send_item(evad_pkg::KIND_END, evad_pkg::LEN_W'($urandom), $urandom);
    endtask

    // hold the sender until all alerts are out and the block has settled
    task automatic wait_quiet();
        @(negedge i_clk);
        item_bus.valid = 1'b0;
        while (sb.expected_alerts.size() != 0)
            @(posedge i_clk);
        repeat (END_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [evad_pkg::CFG_IDX_W-1:0] idx,
                             input logic [evad_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        sb.note_config(idx, data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic set_phase(input int ph);
        logic [evad_pkg::INTERVAL_W-1:0] iv;
        logic [evad_pkg::WEIGHT_W-1:0]   wt;
        logic [evad_pkg::THRESH_W-1:0]   th;
        case (ph % 8)
            0: begin
                iv = 12'd1;
                wt = evad_pkg::WEIGHT_ONE;
                th = evad_pkg::RST_THRESH;
            end
            1: begin
                iv = evad_pkg::INTERVAL_W'($urandom_range(2, 6));
                wt = '0;
                th = '0;
            end
            2: begin
                iv = '0;
                wt = evad_pkg::WEIGHT_W'($urandom_range(1, 65535));
                th = '1;
            end
            3: begin
                iv = '1;
                wt = evad_pkg::WEIGHT_W'($urandom_range(65537, 131071));
                th = evad_pkg::THRESH_W'($urandom_range(256, 1024));
            end
            4: begin
                iv = evad_pkg::INTERVAL_W'($urandom_range(1, 8));
                wt = evad_pkg::WEIGHT_W'($urandom_range(0, 65536));
                th = 16'd256;
            end
            5: begin
                iv = 12'd3600;
                wt = 17'd32768;
                th = evad_pkg::THRESH_W'($urandom);
            end
            6: begin
                iv = evad_pkg::INTERVAL_W'($urandom_range(1, 4));
                wt = 17'd1;
                th = 16'd512;
            end
            default: begin
                iv = evad_pkg::INTERVAL_W'($urandom_range(1, 30));
                wt = evad_pkg::WEIGHT_W'($urandom);
                th = evad_pkg::THRESH_W'($urandom_range(128, 2048));
            end
        endcase
        wait_quiet();
        // unused upper data bits toggle too
        write_reg(evad_pkg::CFG_INTERVAL,
                  {(evad_pkg::CFG_DATA_W-evad_pkg::INTERVAL_W)'($urandom), iv});
        write_reg(evad_pkg::CFG_WEIGHT, wt);
        write_reg(evad_pkg::CFG_THRESH,
                  {(evad_pkg::CFG_DATA_W-evad_pkg::THRESH_W)'($urandom), th});
        write_reg(CFG_UNUSED, evad_pkg::CFG_DATA_W'($urandom));
        case (ph % 4)
            0: begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            1: begin
                src_idle_pct   = 52;
                sink_stall_pct = 0;
            end
            2: begin
                src_idle_pct   = 0;
                sink_stall_pct = 52;
            end
            default: begin
                src_idle_pct   = 38;
                sink_stall_pct = 38;
            end
        endcase
    endtask

    // one measurement interval: a run of packets closed by an end word
    task automatic run_interval();
        int                           style;
        int                           n;
        int                           pick;
        logic [evad_pkg::LEN_W-1:0]   len;
        logic [evad_pkg::TS_W-1:0]    ts;
        style = $urandom_range(99);
        if ($urandom_range(99) < 6)
            send_end();
        if (style < 40)
            n = $urandom_range(1, 3);
        else if (style < 80)
            n = $urandom_range(4, 16);
        else
            n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++) begin
            if (style < 40)
                len = evad_pkg::LEN_W'($urandom_range(0, 255));
            else if (style < 80)
                len = evad_pkg::LEN_W'($urandom_range(4096, 65535));
            else
                len = evad_pkg::LEN_W'($urandom);
            pick = $urandom_range(19);
            ts = (pick == 0) ? '0 : (pick == 1) ? '1 : $urandom;
            send_item(evad_pkg::KIND_PKT, len, ts);
        end
        // a few intervals run on into the next one
        if ($urandom_range(99) >= 5)
            send_end();
        if ($urandom_range(99) < 4)
            wait_quiet();
    endtask

    initial begin
        int ph;
        item_bus.valid      = 1'b0;
        item_bus.kind       = evad_pkg::KIND_PKT;
        item_bus.pkt_len    = '0;
        item_bus.ts_seconds = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = evad_pkg::CFG_INTERVAL;
        cfg_bus.data        = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // end with nothing open: ignored
        send_item(evad_pkg::KIND_END, '1, '1);
        // zero rates seed zero estimates, no alert
        send_item(evad_pkg::KIND_PKT, '0, '1);
        send_item(evad_pkg::KIND_END, '0, '0);
        // zero estimate against a positive byte rate: saturated ratio
        repeat (3) send_item(evad_pkg::KIND_PKT, '1, '0);
        send_end();
        wait_quiet();
        write_reg(evad_pkg::CFG_THRESH, '0);
        write_reg(evad_pkg::CFG_INTERVAL, '0);
        write_reg(evad_pkg::CFG_WEIGHT, '1);
        write_reg(CFG_UNUSED, '1);
        // byte alert again right after one: muted
        send_item(evad_pkg::KIND_PKT, 16'd100, 32'h8000_0000);
        send_item(evad_pkg::KIND_PKT, 16'd100, 32'd1);
        send_end();
        // packet alert alone
        send_item(evad_pkg::KIND_PKT, 16'd0, 32'h7FFF_FFFF);
        send_end();
        send_item(evad_pkg::KIND_PKT, 16'd300, 32'd2);
        send_end();
        wait_quiet();
        write_reg(evad_pkg::CFG_THRESH, '1);
        write_reg(evad_pkg::CFG_WEIGHT, '0);
        send_item(evad_pkg::KIND_PKT, 16'd1, 32'd3);
        send_end();
        wait_quiet();
        write_reg(evad_pkg::CFG_THRESH, '0);
        // both alerts, byte word first
        send_item(evad_pkg::KIND_PKT, 16'd5000, 32'd4);
        send_item(evad_pkg::KIND_PKT, 16'd5000, 32'd5);
        send_end();

        ph = 0;
        while (ph < 8 || (items_sent < TARGET_ITEMS && ph < 16)) begin
            int start;
            set_phase(ph);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS)
                run_interval();
            ph++;
        end

        wait_quiet();
        $display("Covered %0d items, %0d interval closes, %0d alert words, %0d register writes",
                 items_sent, sb.intervals_closed, sb.alerts_checked, sb.reg_writes);
        $display("over %0d setting phases with and without idling on both sides", ph);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
